// ===== rtl/core/mat_pkg.sv =====
// package for the memory admission table
// request, response, table control and alu mode types, status codes and controller states
// no dependencies
`default_nettype none

package mat_pkg;

   localparam int unsigned MAX_ACTIVE_DEF = 5;
   localparam logic [7:0]  RESET_TOTAL    = 8'd100;
   localparam int unsigned ACT_W          = 3;

   typedef enum logic {
      OP_ACQUIRE = 1'b0,
      OP_RELEASE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_GRANTED    = 3'd0,
      ST_NO_MEMORY  = 3'd1,
      ST_TABLE_FULL = 3'd2,
      ST_RELEASED   = 3'd3,
      ST_NOT_FOUND  = 3'd4
   } status_type;

   typedef struct packed {
      opcode_type opcode;
      logic [7:0] proc_id;
      logic [7:0] need;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [7:0]       free_after;
      logic [ACT_W-1:0] active_count;
   } rsp_type;

   typedef struct packed {
      logic append;
      logic compact;
   } tbl_op_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACQ,
      S_SEARCH,
      S_FREE,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/memory_admission_table.sv =====
// memory admission table: acquire and release of a shared pool with a compacted grant table
// steps: an acquire goes through S_ACQ to S_DONE; a release searches the occupied entries
// from entry 0, one entry compared per cycle by the shared alu, then a match goes through
// S_FREE to S_DONE and a miss goes straight to S_DONE; one request at a time, busy drops
// the cycle after the rsp_valid strobe; reset: synchronous, pool reloads to 100 and the
// entry count clears, no clearing pass; rsp_valid is a one-cycle strobe, the receiver cannot
// stall; depends on mat_pkg, mat_alu, mat_table and mat_ctrl
`default_nettype none

module memory_admission_table
   import mat_pkg::*;
#(
   parameter int unsigned MAX_ACTIVE = MAX_ACTIVE_DEF
)(
   input  wire             clock,
   input  wire             reset,
   // request channel
   input  wire             start,
   output logic            busy,
   input  wire req_type    req,
   // response channel
   output logic            rsp_valid,
   output rsp_type         rsp,
   // pool size register, a write while idle reloads the pool and empties the table
   input  wire             csr_we,
   input  wire logic [7:0] csr_wdata
);

   localparam int unsigned IDX_W = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;

   // shared alu hookup
   alu_mode_type     alu_mode;
   logic [7:0]       alu_a;
   logic [7:0]       alu_b;
   logic [8:0]       alu_res;

   // grant table hookup
   tbl_op_type       tbl_op;
   logic [IDX_W-1:0] tbl_wr_idx;
   logic [7:0]       tbl_wr_id;
   logic [7:0]       tbl_wr_size;
   logic [IDX_W-1:0] tbl_rd_idx;
   logic [7:0]       tbl_rd_id;
   logic [7:0]       tbl_rd_size;

   // sequencer: pool amount, entry count, search index and response status
   mat_ctrl #(
      .MAX_ACTIVE (MAX_ACTIVE)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .alu_mode    (alu_mode),
      .alu_a       (alu_a),
      .alu_b       (alu_b),
      .alu_res     (alu_res),
      .tbl_op      (tbl_op),
      .tbl_wr_idx  (tbl_wr_idx),
      .tbl_wr_id   (tbl_wr_id),
      .tbl_wr_size (tbl_wr_size),
      .tbl_rd_idx  (tbl_rd_idx),
      .tbl_rd_id   (tbl_rd_id),
      .tbl_rd_size (tbl_rd_size)
   );

   // one adder/subtractor: pool check, id compare and pool return share it
   mat_alu u_alu (
      .mode   (alu_mode),
      .op_a   (alu_a),
      .op_b   (alu_b),
      .result (alu_res)
   );

   // grant table, new grants go on the end from the held request, a release closes the gap
   // by shifting the entries above it down
   mat_table #(
      .MAX_ACTIVE (MAX_ACTIVE)
   ) u_table (
      .clock    (clock),
      .op       (tbl_op),
      .wr_idx   (tbl_wr_idx),
      .wr_id    (tbl_wr_id),
      .wr_size  (tbl_wr_size),
      .hole_idx (tbl_rd_idx),
      .rd_idx   (tbl_rd_idx),
      .rd_id    (tbl_rd_id),
      .rd_size  (tbl_rd_size)
   );

endmodule

`default_nettype wire

// ===== rtl/core/mat_alu.sv =====
// shared 8-bit add / subtract unit of the memory admission table
// 9-bit result carries the carry or borrow; uses mat_pkg
`default_nettype none

module mat_alu
   import mat_pkg::*;
(
   input  wire alu_mode_type mode,
   input  wire logic [7:0]   op_a,
   input  wire logic [7:0]   op_b,
   output logic      [8:0]   result
);

   always_comb begin
      case (mode)
         ALU_SUB: result = {1'b0, op_a} - {1'b0, op_b};
         default: result = {1'b0, op_a} + {1'b0, op_b};
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/mat_table.sv =====
// grant table of the memory admission table: compacted list of (id, size)
// append at the fill point, single read port, shift-down compaction; uses mat_pkg
`default_nettype none

module mat_table
   import mat_pkg::*;
#(
   parameter  int unsigned MAX_ACTIVE = MAX_ACTIVE_DEF,
   localparam int unsigned IDX_W      = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1
)(
   input  wire                   clock,
   input  wire tbl_op_type       op,
   input  wire logic [IDX_W-1:0] wr_idx,
   input  wire logic [7:0]       wr_id,
   input  wire logic [7:0]       wr_size,
   input  wire logic [IDX_W-1:0] hole_idx,
   input  wire logic [IDX_W-1:0] rd_idx,
   output logic      [7:0]       rd_id,
   output logic      [7:0]       rd_size
);

   logic [7:0] ids_ff   [MAX_ACTIVE];
   logic [7:0] ids_in   [MAX_ACTIVE];
   logic [7:0] sizes_ff [MAX_ACTIVE];
   logic [7:0] sizes_in [MAX_ACTIVE];

   for (genvar k = 0; k < MAX_ACTIVE; k++) begin : g_entry
      logic [7:0] up_id;
      logic [7:0] up_size;
      logic       shift;
      logic       load;

      // neighbour above, or empty past the top
      if (k < MAX_ACTIVE - 1) begin : g_mid
         assign up_id   = ids_ff[k+1];
         assign up_size = sizes_ff[k+1];
      end else begin : g_top
         assign up_id   = '0;
         assign up_size = '0;
      end

      assign shift = op.compact && (IDX_W'(k) >= hole_idx);
      assign load  = op.append && (IDX_W'(k) == wr_idx);

      assign ids_in[k]   = shift ? up_id   : (load ? wr_id   : ids_ff[k]);
      assign sizes_in[k] = shift ? up_size : (load ? wr_size : sizes_ff[k]);
   end

   always_ff @(posedge clock) begin
      ids_ff   <= ids_in;
      sizes_ff <= sizes_in;
   end

   assign rd_id   = ids_ff[rd_idx];
   assign rd_size = sizes_ff[rd_idx];

endmodule

`default_nettype wire

// ===== rtl/core/mat_ctrl.sv =====
// sequencer of the memory admission table: free pool, entry count, search and response
// drives the shared alu and the grant table; uses mat_pkg
`default_nettype none

module mat_ctrl
   import mat_pkg::*;
#(
   parameter  int unsigned MAX_ACTIVE = MAX_ACTIVE_DEF,
   localparam int unsigned IDX_W      = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1
)(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire req_type          req,
   output logic                  rsp_valid,
   output rsp_type               rsp,
   input  wire                   csr_we,
   input  wire logic [7:0]       csr_wdata,
   output alu_mode_type          alu_mode,
   output logic      [7:0]       alu_a,
   output logic      [7:0]       alu_b,
   input  wire logic [8:0]       alu_res,
   output tbl_op_type            tbl_op,
   output logic      [IDX_W-1:0] tbl_wr_idx,
   output logic      [7:0]       tbl_wr_id,
   output logic      [7:0]       tbl_wr_size,
   output logic      [IDX_W-1:0] tbl_rd_idx,
   input  wire logic [7:0]       tbl_rd_id,
   input  wire logic [7:0]       tbl_rd_size
);

   localparam int unsigned CNT_W = $clog2(MAX_ACTIVE + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ACTIVE);

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [7:0]       free_ff, free_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   status_type       status_ff, status_in;

   logic accept;
   logic search_end;
   logic id_match;

   assign accept     = start && (state_ff == S_IDLE);
   assign search_end = (idx_ff >= count_ff);
   assign id_match   = (alu_res == 9'd0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req.opcode == OP_ACQUIRE) ? S_ACQ : S_SEARCH;
            end
         end
         S_ACQ:    state_in = S_DONE;
         S_SEARCH: begin
            if (search_end) begin
               state_in = S_DONE;
            end else if (id_match) begin
               state_in = S_FREE;
            end
         end
         S_FREE:   state_in = S_DONE;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath control and outputs
   always_comb begin
      req_in     = req_ff;
      free_in    = free_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      status_in  = status_ff;
      alu_mode   = ALU_SUB;
      alu_a      = free_ff;
      alu_b      = req_ff.need;
      tbl_op     = '0;
      busy       = 1'b1;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            // a pool write lands ahead of a request taken at the same edge
            if (csr_we) begin
               free_in  = csr_wdata;
               count_in = '0;
            end
            if (accept) begin
               req_in = req;
               idx_in = '0;
            end
         end
         S_ACQ: begin
            // free - need, borrow means not enough pool
            if (alu_res[8]) begin
               status_in = ST_NO_MEMORY;
            end else if (count_ff >= CNT_MAX) begin
               status_in = ST_TABLE_FULL;
            end else begin
               status_in     = ST_GRANTED;
               free_in       = alu_res[7:0];
               count_in      = count_ff + 1'b1;
               tbl_op.append = 1'b1;
            end
         end
         S_SEARCH: begin
            alu_a = req_ff.proc_id;
            alu_b = tbl_rd_id;
            if (search_end) begin
               status_in = ST_NOT_FOUND;
            end else if (!id_match) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FREE: begin
            alu_mode       = ALU_ADD;
            alu_b          = tbl_rd_size;
            free_in        = alu_res[8] ? 8'hFF : alu_res[7:0];
            count_in       = count_ff - 1'b1;
            status_in      = ST_RELEASED;
            tbl_op.compact = 1'b1;
         end
         S_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign tbl_wr_idx  = count_ff[IDX_W-1:0];
   assign tbl_wr_id   = req_ff.proc_id;
   assign tbl_wr_size = req_ff.need;
   assign tbl_rd_idx  = idx_ff[IDX_W-1:0];

   assign rsp.status       = status_ff;
   assign rsp.free_after   = free_ff;
   assign rsp.active_count = ACT_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff  <= RESET_TOTAL;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("entry count above table depth");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after accepting a request");

   a_free_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREE) |=> (rsp_valid && (status_ff == ST_RELEASED)))
      else $error("release did not report");

   a_search_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (idx_ff <= count_ff))
      else $error("search ran past occupied entries");

endmodule

`default_nettype wire
